// ===== rtl/core/sbc_pkg.sv =====
// Shared types and codes for the segment box clip unit
package sbc_pkg;

	localparam int CFG_INDEX_W = 3;

	localparam logic [CFG_INDEX_W-1:0] REG_MIN_X  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MIN_Y  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_MIN_Z  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SIZE_X = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_SIZE_Y = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_SIZE_Z = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_TOL    = 3'd6;

	localparam logic [2:0] FACE_NONE = 3'd0;
	localparam logic [2:0] FACE_LAST = 3'd6;

	localparam int TOL_W = 16;
	localparam logic [TOL_W-1:0] TOL_RESET = 16'd1;

	typedef enum logic [1:0] {
		SIDE_IN,
		SIDE_ON,
		SIDE_OUT
	} side_t;

	typedef struct packed {
		logic       v;
		logic       rej;
		logic [2:0] face;
	} sbc_ctl_t;

endpackage

// ===== rtl/core/sbc_plane.sv =====
// One face plane of the clip: side test, crossing product, pipelined divide, update
module sbc_plane #(
	parameter int W     = 32,
	parameter int AXIS  = 0,
	parameter bit UPPER = 1'b1,
	parameter int FACE  = 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  sbc_pkg::sbc_ctl_t          in_ctl,
	input  logic [2:0][W-1:0]          in_from,
	input  logic [2:0][W-1:0]          in_to,
	input  logic signed [W-1:0]        box_lo,
	input  logic signed [W:0]          box_hi,
	input  logic [sbc_pkg::TOL_W-1:0]  tol,
	output sbc_pkg::sbc_ctl_t          out_ctl,
	output logic [2:0][W-1:0]          out_from,
	output logic [2:0][W-1:0]          out_to
);
	import sbc_pkg::*;

	typedef struct packed {
		logic              rej;
		logic              mv_from;
		logic              mv_to;
		logic [2:0]        face;
		logic [2:0][W-1:0] from;
		logic [2:0][W-1:0] to;
		logic [2:0]        segneg;
		logic [W-1:0]      aden;
	} carry_t;

	function automatic side_t side_of(input logic signed [W+1:0] d, input logic [TOL_W-1:0] t);
		logic [W+1:0] m;
		m = d[W+1] ? (W+2)'(-d) : (W+2)'(d);
		if (m <= (W+2)'(t))
			return SIDE_ON;
		else if (!d[W+1])
			return SIDE_OUT;
		else
			return SIDE_IN;
	endfunction

	logic signed [W+1:0] pf, pt, df, dt, num;
	logic signed [W:0]   den;
	logic [W+1:0]        anum;
	logic [W:0]          aden;
	side_t               sf, st;
	logic                ok, rej_now;
	logic signed [W:0]   sd [3];
	carry_t              ca;

	always_comb begin
		pf = (W+2)'($signed(in_from[AXIS]));
		pt = (W+2)'($signed(in_to[AXIS]));
		if (UPPER) begin
			df = pf - (W+2)'(box_hi);
			dt = pt - (W+2)'(box_hi);
			den = (W+1)'(pt - pf);
		end else begin
			df = (W+2)'(box_lo) - pf;
			dt = (W+2)'(box_lo) - pt;
			den = (W+1)'(pf - pt);
		end
		sf = side_of(df, tol);
		st = side_of(dt, tol);
		num = -df;
		anum = num[W+1] ? (W+2)'(-num) : (W+2)'(num);
		aden = den[W] ? (W+1)'(-den) : (W+1)'(den);
		rej_now = (sf == st) && (sf != SIDE_IN);
		ok = (sf != st) && (den != '0)
			&& ((num == '0) || ((!num[W+1] == !den[W]) && (anum <= (W+2)'(aden))));
		ca.rej = in_ctl.rej || rej_now;
		ca.mv_from = ok && !ca.rej && (sf == SIDE_OUT);
		ca.mv_to = ok && !ca.rej && (st == SIDE_OUT);
		ca.face = in_ctl.face;
		ca.from = in_from;
		ca.to = in_to;
		ca.aden = aden[W-1:0];
		for (int k = 0; k < 3; k++) begin
			sd[k] = (W+1)'($signed(in_to[k])) - (W+1)'($signed(in_from[k]));
			ca.segneg[k] = sd[k][W];
		end
	end

	logic              v_s1;
	carry_t            c_s1;
	logic [W-1:0]      anum_s1;
	logic [2:0][W-1:0] segmag_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en)
			v_s1 <= in_ctl.v;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1 <= ca;
			anum_s1 <= anum[W-1:0];
			for (int k = 0; k < 3; k++)
				segmag_s1[k] <= sd[k][W] ? W'(-sd[k]) : W'(sd[k]);
		end
	end

	logic              dv   [0:W];
	carry_t            dc   [0:W];
	logic [2:0][W-1:0] drem [0:W];
	logic [2:0][W-1:0] dlow [0:W];
	logic [2:0][W-1:0] dq   [0:W];
	logic [2*W-1:0]    prod [3];

	always_comb begin
		for (int k = 0; k < 3; k++)
			prod[k] = (2*W)'(segmag_s1[k]) * (2*W)'(anum_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dv[0] <= 1'b0;
		else if (en)
			dv[0] <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dc[0] <= c_s1;
			for (int k = 0; k < 3; k++) begin
				drem[0][k] <= prod[k][2*W-1:W];
				dlow[0][k] <= prod[k][W-1:0];
				dq[0][k] <= '0;
			end
		end
	end

	for (genvar j = 0; j < W; j++) begin : g_div
		logic [W:0] trial [3];
		logic [2:0] ge;

		always_comb begin
			for (int k = 0; k < 3; k++) begin
				trial[k] = {drem[j][k], dlow[j][k][W-1]};
				ge[k] = trial[k] >= {1'b0, dc[j].aden};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dv[j+1] <= 1'b0;
			else if (en)
				dv[j+1] <= dv[j];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dc[j+1] <= dc[j];
				for (int k = 0; k < 3; k++) begin
					drem[j+1][k] <= ge[k] ? W'(trial[k] - {1'b0, dc[j].aden}) : trial[k][W-1:0];
					dlow[j+1][k] <= {dlow[j][k][W-2:0], 1'b0};
					dq[j+1][k] <= {dq[j][k][W-2:0], ge[k]};
				end
			end
		end
	end

	carry_t              cf;
	logic [W+1:0]        qq [3];
	logic signed [W+1:0] xs [3];
	logic [2:0][W-1:0]   nfrom, nto;
	logic [2:0]          nface;

	always_comb begin
		cf = dc[W];
		nfrom = cf.from;
		nto = cf.to;
		nface = cf.face;
		for (int k = 0; k < 3; k++) begin
			qq[k] = (W+2)'(dq[W][k])
				+ (W+2)'({drem[W][k], 1'b0} >= {1'b0, cf.aden});
			xs[k] = (W+2)'($signed(cf.from[k]))
				+ (cf.segneg[k] ? -$signed(qq[k]) : $signed(qq[k]));
			if (cf.mv_from)
				nfrom[k] = xs[k][W-1:0];
			if (cf.mv_to)
				nto[k] = xs[k][W-1:0];
		end
		if (cf.mv_from)
			nface = 3'(FACE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ctl <= '0;
		end else if (en) begin
			out_ctl.v <= dv[W];
			out_ctl.rej <= cf.rej;
			out_ctl.face <= nface;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_from <= nfrom;
			out_to <= nto;
		end
	end

endmodule

// ===== rtl/core/segment_box_clip_unit.sv =====
// Segment clipping against a configured axis-aligned box, six planes in a deep pipeline
// Throughput: one item per cycle while the output buffer is not full.
// Each plane holds a COORD_WIDTH-stage restoring divider.
// A two-entry output buffer keeps the pipeline moving while one result waits.
// Reset clears all valid bits and sets the box to zero size at the origin, tolerance 1.
// Configuration writes are taken in any cycle.
module segment_box_clip_unit #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [COORD_WIDTH-1:0]       start_x,
	input  logic signed [COORD_WIDTH-1:0]       start_y,
	input  logic signed [COORD_WIDTH-1:0]       start_z,
	input  logic signed [COORD_WIDTH-1:0]       end_x,
	input  logic signed [COORD_WIDTH-1:0]       end_y,
	input  logic signed [COORD_WIDTH-1:0]       end_z,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                hit,
	output logic signed [COORD_WIDTH-1:0]       clip_x,
	output logic signed [COORD_WIDTH-1:0]       clip_y,
	output logic signed [COORD_WIDTH-1:0]       clip_z,
	output logic [2:0]                          entry_face,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [sbc_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [COORD_WIDTH-1:0]              cfg_data
);
	import sbc_pkg::*;

	localparam int W = COORD_WIDTH;

	logic signed [W-1:0] box_min_q [3];
	logic [W-2:0]        box_size_q [3];
	logic [TOL_W-1:0]    tol_q;
	logic signed [W:0]   box_hi [3];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				box_min_q[k] <= '0;
				box_size_q[k] <= '0;
			end
			tol_q <= TOL_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MIN_X:  box_min_q[0] <= cfg_data;
				REG_MIN_Y:  box_min_q[1] <= cfg_data;
				REG_MIN_Z:  box_min_q[2] <= cfg_data;
				REG_SIZE_X: box_size_q[0] <= cfg_data[W-2:0];
				REG_SIZE_Y: box_size_q[1] <= cfg_data[W-2:0];
				REG_SIZE_Z: box_size_q[2] <= cfg_data[W-2:0];
				REG_TOL:    tol_q <= cfg_data[TOL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++)
			box_hi[k] = {box_min_q[k][W-1], box_min_q[k]} + {2'b00, box_size_q[k]};
	end

	logic              en;
	logic              skid_v_q;
	sbc_ctl_t          pc   [0:6];
	logic [2:0][W-1:0] pfrom [0:6];
	logic [2:0][W-1:0] pto   [0:6];

	assign en = !skid_v_q;
	assign in_ready = en;

	always_comb begin
		pc[0].v = in_valid;
		pc[0].rej = 1'b0;
		pc[0].face = FACE_NONE;
		pfrom[0] = {start_z, start_y, start_x};
		pto[0] = {end_z, end_y, end_x};
	end

	for (genvar p = 0; p < 6; p++) begin : g_plane
		sbc_plane #(
			.W     (W),
			.AXIS  (p / 2),
			.UPPER ((p % 2) == 0),
			.FACE  (p + 1)
		) u_plane (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_ctl   (pc[p]),
			.in_from  (pfrom[p]),
			.in_to    (pto[p]),
			.box_lo   (box_min_q[p/2]),
			.box_hi   (box_hi[p/2]),
			.tol      (tol_q),
			.out_ctl  (pc[p+1]),
			.out_from (pfrom[p+1]),
			.out_to   (pto[p+1])
		);
	end

	logic              push, pop;
	logic              r_hit;
	logic [2:0][W-1:0] r_clip;
	logic [2:0]        r_face;
	logic              skid_hit_q;
	logic [2:0][W-1:0] skid_clip_q;
	logic [2:0]        skid_face_q;

	assign push = en && pc[6].v;
	assign pop = out_valid && out_ready;

	always_comb begin
		r_hit = !pc[6].rej;
		r_clip = pc[6].rej ? '0 : pfrom[6];
		r_face = pc[6].rej ? FACE_NONE : pc[6].face;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop)
				skid_v_q <= 1'b0;
		end else if (push) begin
			if (out_valid && !pop)
				skid_v_q <= 1'b1;
			else
				out_valid <= 1'b1;
		end else if (pop) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) begin
				hit <= skid_hit_q;
				{clip_z, clip_y, clip_x} <= skid_clip_q;
				entry_face <= skid_face_q;
			end
		end else if (push) begin
			if (out_valid && !pop) begin
				skid_hit_q <= r_hit;
				skid_clip_q <= r_clip;
				skid_face_q <= r_face;
			end else begin
				hit <= r_hit;
				{clip_z, clip_y, clip_x} <= r_clip;
				entry_face <= r_face;
			end
		end
	end

endmodule

// ===== rtl/core/sbc_checker.sv =====
// Port-level checks for the segment box clip unit, bound to the top level
module sbc_checker #(
	parameter int COORD_WIDTH = 32
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          hit,
	input logic signed [COORD_WIDTH-1:0] clip_x,
	input logic signed [COORD_WIDTH-1:0] clip_y,
	input logic signed [COORD_WIDTH-1:0] clip_z,
	input logic [2:0]                    entry_face
);
	import sbc_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(clip_x)
			&& $stable(entry_face))
		else $error("output item changed while stalled");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> entry_face == FACE_NONE && clip_x == '0
			&& clip_y == '0 && clip_z == '0)
		else $error("rejected item carries nonzero fields");

	a_face_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> entry_face <= FACE_LAST)
		else $error("entry face out of range");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with empty output");

endmodule

bind segment_box_clip_unit sbc_checker #(.COORD_WIDTH(COORD_WIDTH)) u_sbc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.hit        (hit),
	.clip_x     (clip_x),
	.clip_y     (clip_y),
	.clip_z     (clip_z),
	.entry_face (entry_face)
);
